// ----- src/c_subset_tokenizer_core_defines.svh -----
// Assertion macros for the tokenizer core.
// Used by the lexer step and the result queue; needs nothing else.
`ifndef C_SUBSET_TOKENIZER_CORE_DEFINES_SVH
`define C_SUBSET_TOKENIZER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CST_ASSERT_IMPL(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// antecedent implies consequent in the next cycle
`define CST_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

// ----- src/cst_pkg.sv -----
// Shared types, token codes, character codes and helper functions
// for the tokenizer core. No dependencies.
`timescale 1ns / 1ps

package cst_pkg;

	localparam int WORD_CHARS = 8;
	localparam int KW_COUNT = 9;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW = $clog2(RQ_DEPTH);
	localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_NUMBAD, M_SLASH,
		M_LINECOM, M_BLOCK, M_BLOCKSTAR, M_PENDOP
	} lex_mode_t;

	localparam logic [5:0] TOK_NONE = 6'd0;
	localparam logic [5:0] TOK_IDENT = 6'd1;
	localparam logic [5:0] TOK_CONST = 6'd2;
	localparam logic [5:0] TOK_PLUS = 6'd3;
	localparam logic [5:0] TOK_MINUS = 6'd4;
	localparam logic [5:0] TOK_MUL = 6'd5;
	localparam logic [5:0] TOK_DIV = 6'd6;
	localparam logic [5:0] TOK_MOD = 6'd7;
	localparam logic [5:0] TOK_LT = 6'd8;
	localparam logic [5:0] TOK_LE = 6'd9;
	localparam logic [5:0] TOK_GT = 6'd10;
	localparam logic [5:0] TOK_GE = 6'd11;
	localparam logic [5:0] TOK_EQ = 6'd12;
	localparam logic [5:0] TOK_NE = 6'd13;
	localparam logic [5:0] TOK_ANDAND = 6'd14;
	localparam logic [5:0] TOK_OROR = 6'd15;
	localparam logic [5:0] TOK_ASSIGN = 6'd16;
	localparam logic [5:0] TOK_LPAREN = 6'd17;
	localparam logic [5:0] TOK_RPAREN = 6'd18;
	localparam logic [5:0] TOK_LBRACK = 6'd19;
	localparam logic [5:0] TOK_RBRACK = 6'd20;
	localparam logic [5:0] TOK_LBRACE = 6'd21;
	localparam logic [5:0] TOK_RBRACE = 6'd22;
	localparam logic [5:0] TOK_SEMI = 6'd23;
	localparam logic [5:0] TOK_COMMA = 6'd24;
	localparam logic [5:0] TOK_KW_BASE = 6'd25;

	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_LT = 8'h3c;
	localparam logic [7:0] CH_EQ = 8'h3d;
	localparam logic [7:0] CH_GT = 8'h3e;
	localparam logic [7:0] CH_LBRK = 8'h5b;
	localparam logic [7:0] CH_RBRK = 8'h5d;
	localparam logic [7:0] CH_LBRC = 8'h7b;
	localparam logic [7:0] CH_BAR = 8'h7c;
	localparam logic [7:0] CH_RBRC = 8'h7d;

	// void int float char if else while do return, first character in low byte
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'h0000_0000_6469_6f76,
		64'h0000_0000_0074_6e69,
		64'h0000_0074_616f_6c66,
		64'h0000_0000_7261_6863,
		64'h0000_0000_0000_6669,
		64'h0000_0000_6573_6c65,
		64'h0000_0065_6c69_6877,
		64'h0000_0000_0000_6f64,
		64'h0000_6e72_7574_6572
	};
	localparam logic [7:0] KW_LEN [KW_COUNT] = '{
		8'd4, 8'd3, 8'd5, 8'd4, 8'd2, 8'd4, 8'd5, 8'd2, 8'd6
	};

	typedef struct packed {
		logic kind;
		logic [5:0] token_code;
		logic [63:0] word_text;
		logic [7:0] word_len;
		logic [31:0] number_value;
		logic truncated;
		logic [15:0] line_number;
		logic run_last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t [1:0] slot;
	} lex_push_t;

	typedef struct packed {
		lex_mode_t mode;
		logic [7:0] pend;
		logic [63:0] wbuf;
		logic [7:0] wcnt;
		logic [31:0] acc;
		logic ovf;
		logic [15:0] line;
		logic [15:0] lerr;
	} lex_state_t;

	typedef struct packed {
		logic valid;
		result_t res;
		logic [15:0] lerr;
	} flush_t;

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
	endfunction

	function automatic logic [15:0] line_inc(input logic [15:0] l);
		line_inc = (l != 16'hffff) ? l + 16'd1 : l;
	endfunction

	function automatic result_t tok_res(input logic [5:0] code, input logic [15:0] line);
		result_t r;
		r = '0;
		r.kind = KIND_TOKEN;
		r.token_code = code;
		r.line_number = line;
		tok_res = r;
	endfunction

	function automatic logic [5:0] kw_code(input logic [63:0] txt, input logic [7:0] len);
		logic [5:0] code;
		code = TOK_NONE;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (txt == KW_TEXT[k] && len == KW_LEN[k]) begin
				code = TOK_KW_BASE + 6'(k);
			end
		end
		kw_code = code;
	endfunction

	function automatic logic [5:0] op_code(input logic [7:0] c);
		logic [5:0] code;
		case (c)
			CH_PLUS: code = TOK_PLUS;
			CH_MINUS: code = TOK_MINUS;
			CH_STAR: code = TOK_MUL;
			CH_PCT: code = TOK_MOD;
			CH_LPAR: code = TOK_LPAREN;
			CH_RPAR: code = TOK_RPAREN;
			CH_LBRK: code = TOK_LBRACK;
			CH_RBRK: code = TOK_RBRACK;
			CH_LBRC: code = TOK_LBRACE;
			CH_RBRC: code = TOK_RBRACE;
			CH_SEMI: code = TOK_SEMI;
			CH_COMMA: code = TOK_COMMA;
			default: code = TOK_NONE;
		endcase
		op_code = code;
	endfunction

	// result of closing whatever token the state holds
	function automatic flush_t flush_of(input lex_state_t s);
		flush_t f;
		logic [5:0] kc;
		logic err;
		f.valid = 1'b0;
		f.res = tok_res(TOK_NONE, s.line);
		f.lerr = s.lerr;
		kc = TOK_NONE;
		err = 1'b0;
		case (s.mode)
			M_IDENT: begin
				f.valid = 1'b1;
				if (s.wcnt <= 8'(WORD_CHARS)) begin
					kc = kw_code(s.wbuf, s.wcnt);
				end
				if (kc != TOK_NONE) begin
					f.res.token_code = kc;
				end else begin
					f.res.token_code = TOK_IDENT;
					f.res.word_text = s.wbuf;
					f.res.word_len = s.wcnt;
					f.res.truncated = s.wcnt > 8'(WORD_CHARS);
				end
			end
			M_NUMBER: begin
				f.valid = 1'b1;
				f.res.token_code = TOK_CONST;
				f.res.number_value = s.acc;
				f.res.truncated = s.ovf;
			end
			M_NUMBAD: err = 1'b1;
			M_SLASH: begin
				f.valid = 1'b1;
				f.res.token_code = TOK_DIV;
			end
			M_PENDOP: begin
				case (s.pend)
					CH_LT: begin
						f.valid = 1'b1;
						f.res.token_code = TOK_LT;
					end
					CH_GT: begin
						f.valid = 1'b1;
						f.res.token_code = TOK_GT;
					end
					CH_EQ: begin
						f.valid = 1'b1;
						f.res.token_code = TOK_ASSIGN;
					end
					default: err = 1'b1;
				endcase
			end
			default: ;
		endcase
		if (err && s.line != s.lerr) begin
			f.valid = 1'b1;
			f.res.kind = KIND_ERROR;
			f.lerr = s.line;
		end
		flush_of = f;
	endfunction

endpackage

// ----- src/cst_lex.sv -----
// Lexer step: input register, lexer state and the per-character update.
// Depends on cst_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "c_subset_tokenizer_core_defines.svh"

module cst_lex import cst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] ch,
	input logic end_of_text,
	input logic room,
	output lex_push_t push
);

	logic valid_s1;
	logic [7:0] ch_s1;
	logic eot_s1;
	logic process;
	logic accept;

	lex_state_t st_q;
	lex_state_t nx;
	lex_state_t rst_state;
	flush_t f1;
	flush_t f2;
	logic do_flush;
	logic do_start;
	logic [5:0] pc;
	logic [5:0] oc;
	logic [35:0] prod;
	logic [1:0] n;
	result_t [1:0] slot;

	assign process = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept = in_valid && !in_stall;

	always_comb begin
		rst_state = '0;
		rst_state.mode = M_IDLE;
		rst_state.line = 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !process);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= ch;
			eot_s1 <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rst_state;
		end else if (process) begin
			st_q <= nx;
		end
	end

	always_comb begin
		nx = st_q;
		n = 2'd0;
		slot = '0;
		do_flush = 1'b0;
		do_start = 1'b0;
		pc = TOK_NONE;
		oc = TOK_NONE;
		prod = '0;
		f1 = '0;
		f2 = '0;

		case (st_q.mode)
			M_LINECOM: begin
				if (ch_s1 == CH_NL) begin
					nx.mode = M_IDLE;
					nx.line = line_inc(st_q.line);
				end
			end
			M_BLOCK: begin
				if (ch_s1 == CH_STAR) begin
					nx.mode = M_BLOCKSTAR;
				end else if (ch_s1 == CH_NL) begin
					nx.line = line_inc(st_q.line);
				end
			end
			M_BLOCKSTAR: begin
				if (ch_s1 == CH_SLASH) begin
					nx.mode = M_IDLE;
				end else if (ch_s1 != CH_STAR) begin
					nx.mode = M_BLOCK;
					if (ch_s1 == CH_NL) begin
						nx.line = line_inc(st_q.line);
					end
				end
			end
			M_IDENT: begin
				if (is_alpha(ch_s1) || is_digit(ch_s1)) begin
					for (int k = 0; k < WORD_CHARS; k++) begin
						if (st_q.wcnt == 8'(k)) begin
							nx.wbuf[8*k +: 8] = ch_s1;
						end
					end
					if (st_q.wcnt != 8'hff) begin
						nx.wcnt = st_q.wcnt + 8'd1;
					end
				end else begin
					do_flush = 1'b1;
				end
			end
			M_NUMBER: begin
				if (is_digit(ch_s1)) begin
					prod = ({4'b0, st_q.acc} << 3) + ({4'b0, st_q.acc} << 1)
						+ 36'(ch_s1 - 8'h30);
					if (prod[35:32] != 4'd0) begin
						nx.acc = 32'hffff_ffff;
						nx.ovf = 1'b1;
					end else begin
						nx.acc = prod[31:0];
					end
				end else if (is_alpha(ch_s1)) begin
					nx.mode = M_NUMBAD;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_NUMBAD: begin
				if (!(is_alpha(ch_s1) || is_digit(ch_s1))) begin
					do_flush = 1'b1;
				end
			end
			M_SLASH: begin
				if (ch_s1 == CH_SLASH) begin
					nx.mode = M_LINECOM;
				end else if (ch_s1 == CH_STAR) begin
					nx.mode = M_BLOCK;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_PENDOP: begin
				if (ch_s1 == CH_EQ) begin
					case (st_q.pend)
						CH_LT: pc = TOK_LE;
						CH_GT: pc = TOK_GE;
						CH_EQ: pc = TOK_EQ;
						CH_BANG: pc = TOK_NE;
						default: pc = TOK_NONE;
					endcase
				end else if (ch_s1 == CH_AMP && st_q.pend == CH_AMP) begin
					pc = TOK_ANDAND;
				end else if (ch_s1 == CH_BAR && st_q.pend == CH_BAR) begin
					pc = TOK_OROR;
				end
				if (pc != TOK_NONE) begin
					slot[0] = tok_res(pc, st_q.line);
					n = 2'd1;
					nx.mode = M_IDLE;
				end else begin
					do_flush = 1'b1;
				end
			end
			default: begin
				nx.mode = M_IDLE;
				do_start = 1'b1;
			end
		endcase

		if (do_flush) begin
			f1 = flush_of(st_q);
			if (f1.valid) begin
				slot[n[0]] = f1.res;
				n = n + 2'd1;
			end
			nx.lerr = f1.lerr;
			nx.mode = M_IDLE;
			do_start = 1'b1;
		end

		if (do_start) begin
			oc = op_code(ch_s1);
			if (ch_s1 == CH_NL) begin
				nx.line = line_inc(nx.line);
			end else if (is_space(ch_s1)) begin
				nx.mode = M_IDLE;
			end else if (is_digit(ch_s1)) begin
				nx.mode = M_NUMBER;
				nx.acc = 32'(ch_s1 - 8'h30);
				nx.ovf = 1'b0;
			end else if (is_alpha(ch_s1)) begin
				nx.mode = M_IDENT;
				nx.wbuf = {56'd0, ch_s1};
				nx.wcnt = 8'd1;
			end else if (ch_s1 == CH_SLASH) begin
				nx.mode = M_SLASH;
			end else if (ch_s1 inside {CH_LT, CH_GT, CH_EQ, CH_BANG, CH_AMP, CH_BAR}) begin
				nx.mode = M_PENDOP;
				nx.pend = ch_s1;
			end else if (oc != TOK_NONE) begin
				slot[n[0]] = tok_res(oc, nx.line);
				n = n + 2'd1;
			end else if (nx.line != nx.lerr) begin
				slot[n[0]] = tok_res(TOK_NONE, nx.line);
				slot[n[0]].kind = KIND_ERROR;
				n = n + 2'd1;
				nx.lerr = nx.line;
			end
		end

		if (eot_s1) begin
			f2 = flush_of(nx);
			if (f2.valid) begin
				slot[n[0]] = f2.res;
				n = n + 2'd1;
			end
			nx = rst_state;
		end

		if (n == 2'd1) begin
			slot[0].run_last = 1'b1;
		end else if (n == 2'd2) begin
			slot[1].run_last = 1'b1;
		end
	end

	assign push.n = process ? n : 2'd0;
	assign push.slot = slot;

	`CST_ASSERT_IMPL(a_line_nonzero, clk, arst_n, 1'b1, st_q.line != 16'd0)
	`CST_ASSERT_IMPL(a_two_last, clk, arst_n, push.n == 2'd2,
		!push.slot[0].run_last && push.slot[1].run_last)
	`CST_ASSERT_IMPL(a_one_last, clk, arst_n, push.n == 2'd1, push.slot[0].run_last)
	`CST_ASSERT_NEXT(a_eot_reset, clk, arst_n, process && eot_s1,
		st_q.mode == M_IDLE && st_q.line == 16'd1 && st_q.lerr == 16'd0)

endmodule

// ----- src/cst_rq.sv -----
// Result queue: takes up to two results a cycle when it has room, hands out one unless the output stalls.
// Depends on cst_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "c_subset_tokenizer_core_defines.svh"

module cst_rq import cst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input lex_push_t push,
	output logic room,
	output logic out_valid,
	input logic out_stall,
	output result_t head
);

	result_t mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q;
	logic [RQ_AW-1:0] rd_ptr_q;
	logic [RQ_CW-1:0] count_q;
	logic pop;

	assign out_valid = count_q != '0;
	assign pop = out_valid && !out_stall;
	assign room = count_q <= RQ_CW'(RQ_DEPTH - 2);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push.n);
			rd_ptr_q <= rd_ptr_q + RQ_AW'(pop);
			count_q <= count_q + RQ_CW'(push.n) - RQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.slot[0];
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + RQ_AW'(1)] <= push.slot[1];
		end
	end

	`CST_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= RQ_CW'(RQ_DEPTH))
	`CST_ASSERT_IMPL(a_push_fits, clk, arst_n, push.n != 2'd0,
		count_q <= RQ_CW'(RQ_DEPTH - 2))
	`CST_ASSERT_NEXT(a_pop_only, clk, arst_n, pop && push.n == 2'd0,
		count_q == $past(count_q) - RQ_CW'(1))

endmodule

// ----- src/c_subset_tokenizer_core.sv -----
// Tokenizer core top level: lexer step feeding a four-entry result queue.
// Depends on cst_pkg, cst_lex and cst_rq.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | ch, end_of_text
//   out     | out_valid/out_stall| kind, token_code, word_text, word_len,
//           |                    | number_value, truncated, line_number,
//           |                    | run_last
//
// One character per cycle unless the input stalls: a beat is registered,
// then handled, pushing zero, one or two results into the result queue.
// An item producing two results hands them out one after the other; the
// queue depth of four sets how far input runs ahead of output.
// Reset clears the lexer state (line 1, no error seen) and empties the queue.
// Input stalls while a registered beat waits for two free queue entries.
`timescale 1ns / 1ps

module c_subset_tokenizer_core import cst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] ch,
	input logic end_of_text,
	output logic out_valid,
	input logic out_stall,
	output logic kind,
	output logic [5:0] token_code,
	output logic [63:0] word_text,
	output logic [7:0] word_len,
	output logic [31:0] number_value,
	output logic truncated,
	output logic [15:0] line_number,
	output logic run_last
);

	lex_push_t push;
	logic room;
	result_t head;

	cst_lex u_lex (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.end_of_text(end_of_text),
		.room(room),
		.push(push)
	);

	cst_rq u_rq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head(head)
	);

	assign kind = head.kind;
	assign token_code = head.token_code;
	assign word_text = head.word_text;
	assign word_len = head.word_len;
	assign number_value = head.number_value;
	assign truncated = head.truncated;
	assign line_number = head.line_number;
	assign run_last = head.run_last;

endmodule
